// File: src/fdr_pkg.sv
// types and constants of the rusanov face dissipation pipeline
package fdr_pkg;

  localparam int DATA_W    = 32;
  localparam int MAG_W     = 31;
  localparam int NRM_W     = 16;
  localparam int COMP_W    = 2;
  localparam int NORM_FRAC = 15;
  localparam int PROD_W    = DATA_W + NRM_W;
  localparam int VN_W      = PROD_W + 1 - NORM_FRAC;
  localparam int ABS_W     = 33;
  localparam int SPLIT_W   = 24;
  localparam int STAGES    = 9;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic        [MAG_W-1:0]  mag_t;
  typedef logic signed [NRM_W-1:0]  nrm_t;
  typedef logic        [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [VN_W-1:0]   vn_t;
  typedef logic        [ABS_W-1:0]  abs_t;

endpackage

// File: src/face_dissipation_rusanov.sv
// rusanov face dissipation: nine stage pipeline from velocities to scaled difference
// one item per cycle unless stalled; every stage is a register slice with its own valid bit
// empty stages fill while the output waits, so the input stalls only when all stages are full
// synchronous reset clears the valid bits only; payload registers are not reset
module face_dissipation_rusanov #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  fdr_pkg::data_t  u_left,
  input  fdr_pkg::data_t  v_left,
  input  fdr_pkg::mag_t   c_left,
  input  fdr_pkg::data_t  u_right,
  input  fdr_pkg::data_t  v_right,
  input  fdr_pkg::mag_t   c_right,
  input  fdr_pkg::nrm_t   normal_x,
  input  fdr_pkg::nrm_t   normal_y,
  input  fdr_pkg::mag_t   face_length,
  input  fdr_pkg::data_t  state_difference,
  input  fdr_pkg::comp_t  component,
  output logic            out_valid,
  input  logic            out_stall,
  output fdr_pkg::data_t  dissipation,
  output fdr_pkg::comp_t  component_out
);

  import fdr_pkg::*;

  localparam int SPD_W  = 2 * DATA_W - FRAC_BITS;
  localparam int HI_W   = SPD_W - SPLIT_W;
  localparam int PLO_W  = SPLIT_W + 1 + DATA_W;
  localparam int PHI_W  = HI_W + 1 + DATA_W;
  localparam int FULL_W = SPD_W + 1 + DATA_W;
  localparam int Q_W    = FULL_W - FRAC_BITS - 1;
  localparam int T_W    = VN_W + 1;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  // stage 0: normal projections
  prod_t ul_nx, vl_ny, ur_nx, vr_ny;
  mag_t  cl0, cr0, len0;
  data_t diff0;
  comp_t comp0;

  // stage 1: normal velocities
  vn_t   vnl, vnr;
  mag_t  cl1, cr1, len1;
  data_t diff1;
  comp_t comp1;

  // stage 2: absolute wave speeds
  abs_t  wav [6];
  mag_t  len2;
  data_t diff2;
  comp_t comp2;

  // stage 3: scaled speeds
  logic [SPD_W-1:0] spd [6];
  data_t diff3;
  comp_t comp3;

  // stage 4 and 5: maximum
  logic [SPD_W-1:0] pmax [3];
  data_t diff4;
  comp_t comp4;
  logic [SPD_W-1:0] mx;
  data_t diff5;
  comp_t comp5;

  // stage 6 and 7: product with difference
  logic signed [PLO_W-1:0] plo;
  logic signed [PHI_W-1:0] phi;
  comp_t comp6;
  logic signed [FULL_W-1:0] full;
  comp_t comp7;

  vn_t vnl_next, vnr_next;
  abs_t wav_next [6];
  logic [SPD_W-1:0] spd_next [6];
  logic [SPD_W-1:0] mx_next;
  logic signed [FULL_W-1:0] full_next;
  logic signed [Q_W-1:0] q;
  data_t dis_next;

  function automatic abs_t abs_sum(vn_t vn, mag_t c, logic sub);
    logic signed [T_W-1:0] t;
    logic signed [T_W-1:0] a;
    t = sub ? (T_W'(vn) - $signed({1'b0, c})) : (T_W'(vn) + $signed({1'b0, c}));
    a = t[T_W-1] ? -t : t;
    return a[ABS_W-1:0];
  endfunction

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_comb begin
    logic signed [PROD_W:0] sl, sr;
    sl = (PROD_W + 1)'(ul_nx) + (PROD_W + 1)'(vl_ny);
    sr = (PROD_W + 1)'(ur_nx) + (PROD_W + 1)'(vr_ny);
    vnl_next = sl[PROD_W:NORM_FRAC];
    vnr_next = sr[PROD_W:NORM_FRAC];
  end

  always_comb begin
    wav_next[0] = abs_sum(vnl, cl1, 1'b1);
    wav_next[1] = abs_sum(vnl, cl1, 1'b0);
    wav_next[2] = abs_sum(vnl, '0, 1'b0);
    wav_next[3] = abs_sum(vnr, cr1, 1'b1);
    wav_next[4] = abs_sum(vnr, cr1, 1'b0);
    wav_next[5] = abs_sum(vnr, '0, 1'b0);
  end

  always_comb begin
    logic [2*DATA_W-1:0] p;
    for (int i = 0; i < 6; i++) begin
      p = (2 * DATA_W)'(wav[i]) * (2 * DATA_W)'(len2);
      spd_next[i] = p[2*DATA_W-1:FRAC_BITS];
    end
  end

  always_comb begin
    mx_next = pmax[0];
    if (pmax[1] > mx_next) begin
      mx_next = pmax[1];
    end
    if (pmax[2] > mx_next) begin
      mx_next = pmax[2];
    end
  end

  assign full_next = (FULL_W'(phi) <<< SPLIT_W) + FULL_W'(plo);

  always_comb begin
    logic [Q_W-DATA_W:0] top;
    q   = full[FULL_W-1:FRAC_BITS+1];
    top = q[Q_W-1:DATA_W-1];
    if (&top || ~|top) begin
      dis_next = q[DATA_W-1:0];
    end else if (q[Q_W-1]) begin
      dis_next = SAT_MIN;
    end else begin
      dis_next = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ul_nx <= PROD_W'(u_left) * PROD_W'(normal_x);
      vl_ny <= PROD_W'(v_left) * PROD_W'(normal_y);
      ur_nx <= PROD_W'(u_right) * PROD_W'(normal_x);
      vr_ny <= PROD_W'(v_right) * PROD_W'(normal_y);
      cl0   <= c_left;
      cr0   <= c_right;
      len0  <= face_length;
      diff0 <= state_difference;
      comp0 <= component;
    end
    if (en[1]) begin
      vnl   <= vnl_next;
      vnr   <= vnr_next;
      cl1   <= cl0;
      cr1   <= cr0;
      len1  <= len0;
      diff1 <= diff0;
      comp1 <= comp0;
    end
    if (en[2]) begin
      wav   <= wav_next;
      len2  <= len1;
      diff2 <= diff1;
      comp2 <= comp1;
    end
    if (en[3]) begin
      spd   <= spd_next;
      diff3 <= diff2;
      comp3 <= comp2;
    end
    if (en[4]) begin
      pmax[0] <= (spd[1] > spd[0]) ? spd[1] : spd[0];
      pmax[1] <= (spd[3] > spd[2]) ? spd[3] : spd[2];
      pmax[2] <= (spd[5] > spd[4]) ? spd[5] : spd[4];
      diff4   <= diff3;
      comp4   <= comp3;
    end
    if (en[5]) begin
      mx    <= mx_next;
      diff5 <= diff4;
      comp5 <= comp4;
    end
    if (en[6]) begin
      plo   <= $signed({1'b0, mx[SPLIT_W-1:0]}) * PLO_W'(diff5);
      phi   <= $signed({1'b0, mx[SPD_W-1:SPLIT_W]}) * PHI_W'(diff5);
      comp6 <= comp5;
    end
    if (en[7]) begin
      full  <= full_next;
      comp7 <= comp6;
    end
    if (en[8]) begin
      dissipation   <= dis_next;
      component_out <= comp7;
    end
  end

`ifndef SYNTHESIS
  // input is held back only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input stalled with an empty stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // result keeps the sign of the exact product, whether saturated or not
  a_sign: assert property (@(posedge clk) disable iff (rst)
    (vld[7] && en[8]) |=> (dissipation[DATA_W-1] == $past(full[FULL_W-1])))
    else $error("dissipation sign differs from product sign");
`endif

endmodule
